// ===== sv/slt_pkg.sv =====
`default_nettype none
package slt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int FIELD_W  = 7;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_DEL_ONE = 3'd1;
  localparam logic [2:0] CMD_DEL_ALL = 3'd2;
  localparam logic [2:0] CMD_FIND    = 3'd3;
  localparam logic [2:0] CMD_COUNT   = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] removed;
    logic [FIELD_W-1:0] count;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/slt_if.sv =====
`default_nettype none
interface slt_cmd_if;
  import slt_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slt_res_if;
  import slt_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/slt_ram.sv =====
`default_nettype none
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/sorted_list_table.sv =====
// Count, clear, insert into a full table and lookups on an empty table go straight to the
// result state; deletes and find scan the stored entries from the bottom, and insert (but on
// an empty table) scans from the top, reading one stored entry per cycle from the RAM.
// The response register is loaded as the table returns to idle and takes the next request;
// a finished result holds in the result state while the previous response waits to transfer.
// Reset (synchronous, active high) empties the table; entry storage is not cleared.
`default_nettype none
module sorted_list_table (
  input wire logic   clk,
  input wire logic   rst,
  slt_cmd_if.sink    request,
  slt_res_if.source  response
);
  import slt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_SCAN = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t                  st;
  logic [2:0]              cmd;
  logic signed [VAL_W-1:0] key;
  logic [CNT_W-1:0]        used;
  logic [IDX_W-1:0]        ptr;
  logic [CNT_W-1:0]        left;
  logic                    d_vld;
  logic [IDX_W-1:0]        d_idx;
  logic                    d_last;
  logic                    matched;
  logic [IDX_W-1:0]        pos;
  logic [CNT_W-1:0]        n;
  logic [IDX_W-1:0]        w;
  res_t                    res;

  logic                    rd_en;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic [VAL_W-1:0]        rdata;

  logic                    gt;
  logic                    eq;
  logic                    hit_now;
  logic [CNT_W-1:0]        n_fin;
  logic [CNT_W-1:0]        rem;
  logic [IDX_W-1:0]        pos_fin;

  assign request.ready = (st == S_IDLE);
  assign rd_en = ((st == S_INS) || (st == S_SCAN)) && (left != '0);

  assign gt      = $signed(rdata) > key;
  assign eq      = (rdata == key);
  assign hit_now = !matched && eq;
  assign pos_fin = hit_now ? d_idx : pos;

  always_comb begin
    if (hit_now) begin
      n_fin = CNT_W'(1);
    end else if (matched && (cmd == CMD_DEL_ALL) && eq) begin
      n_fin = CNT_W'(n + CNT_W'(1));
    end else begin
      n_fin = n;
    end
    rem = (cmd == CMD_FIND) ? '0 : n_fin;
  end

  // Write port: shift up and place the new key during insert, compact during deletes
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata;
    unique case (st)
      S_INS: begin
        if (d_vld) begin
          wr_en   = 1'b1;
          wr_addr = IDX_W'(d_idx + IDX_W'(1));
          wr_data = gt ? rdata : key;
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        wr_data = key;
      end
      S_SCAN: begin
        if (d_vld && matched && !((cmd == CMD_DEL_ALL) && eq) && (cmd != CMD_FIND)) begin
          wr_en   = 1'b1;
          wr_addr = w;
          wr_data = rdata;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  slt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      used           <= '0;
      left           <= '0;
      d_vld          <= 1'b0;
      response.valid <= 1'b0;
    end else begin
      if (response.ready && (st != S_RESP)) begin
        response.valid <= 1'b0;
      end

      // Read pipeline: one address per cycle, data tagged in the cycle after its address
      d_vld  <= rd_en;
      d_idx  <= ptr;
      d_last <= (left == CNT_W'(1));
      if (rd_en) begin
        left <= CNT_W'(left - CNT_W'(1));
        ptr  <= (st == S_INS) ? IDX_W'(ptr - IDX_W'(1)) : IDX_W'(ptr + IDX_W'(1));
      end

      unique case (st)
        S_IDLE: begin
          if (request.valid) begin
            cmd          <= request.data.command;
            key          <= request.data.value;
            matched      <= 1'b0;
            n            <= '0;
            pos          <= '0;
            res.found    <= 1'b0;
            res.position <= '0;
            unique case (request.data.command) inside
              CMD_INSERT: begin
                res.removed <= '0;
                res.count   <= FIELD_W'(used);
                if (used >= CNT_W'(CAPACITY)) begin
                  res.status <= STAT_FULL;
                  st         <= S_RESP;
                end else if (used == '0) begin
                  res.status <= STAT_OK;
                  st         <= S_PUT;
                end else begin
                  res.status <= STAT_OK;
                  ptr        <= IDX_W'(used - CNT_W'(1));
                  left       <= used;
                  st         <= S_INS;
                end
              end
              CMD_DEL_ONE, CMD_DEL_ALL, CMD_FIND: begin
                res.removed <= '0;
                res.count   <= FIELD_W'(used);
                if (used == '0) begin
                  res.status <= STAT_MISS;
                  st         <= S_RESP;
                end else begin
                  res.status <= STAT_OK;
                  ptr        <= '0;
                  left       <= used;
                  st         <= S_SCAN;
                end
              end
              CMD_CLEAR: begin
                res.status  <= STAT_OK;
                res.removed <= FIELD_W'(used);
                res.count   <= '0;
                used        <= '0;
                st          <= S_RESP;
              end
              default: begin
                res.status  <= STAT_OK;
                res.removed <= '0;
                res.count   <= FIELD_W'(used);
                st          <= S_RESP;
              end
            endcase
          end
        end
        S_INS: begin
          if (d_vld) begin
            if (!gt) begin
              res.position <= FIELD_W'(d_idx + IDX_W'(1));
              res.count    <= FIELD_W'(used + CNT_W'(1));
              used         <= CNT_W'(used + CNT_W'(1));
              st           <= S_RESP;
            end else if (d_last) begin
              pos <= '0;
              st  <= S_PUT;
            end
          end
        end
        S_PUT: begin
          res.position <= FIELD_W'(pos);
          res.count    <= FIELD_W'(used + CNT_W'(1));
          used         <= CNT_W'(used + CNT_W'(1));
          st           <= S_RESP;
        end
        S_SCAN: begin
          if (d_vld) begin
            if (hit_now) begin
              matched <= 1'b1;
              pos     <= d_idx;
              n       <= CNT_W'(1);
              w       <= d_idx;
            end else if (matched) begin
              if ((cmd == CMD_DEL_ALL) && eq) begin
                n <= CNT_W'(n + CNT_W'(1));
              end else begin
                w <= IDX_W'(w + IDX_W'(1));
              end
            end
            if ((hit_now && (cmd == CMD_FIND)) || d_last) begin
              st <= S_RESP;
              if (matched || hit_now) begin
                res.found    <= 1'b1;
                res.position <= FIELD_W'(pos_fin);
                res.removed  <= FIELD_W'(rem);
                res.count    <= FIELD_W'(used - rem);
                used         <= CNT_W'(used - rem);
              end else begin
                res.status <= STAT_MISS;
              end
            end
          end
        end
        S_RESP: begin
          // Hold the result until the output register is free
          if (!response.valid || response.ready) begin
            response.valid <= 1'b1;
            response.data  <= res;
            st             <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CNT_W'(wr_addr) <= used))
    else $error("write beyond the held entries");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((st == S_INS) || (st == S_PUT) || (st == S_SCAN)))
    else $error("write outside an operation");

  a_resp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(response.valid) |-> $past(st == S_RESP))
    else $error("response raised outside the result state");

  a_read_stops: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |=> !d_vld)
    else $error("stale read after return to idle");

endmodule
`default_nettype wire
